// ----- hw/rtl/modexp_pkg.sv -----
// shared constants for the modular exponentiation block
package modexp_pkg;

    localparam int DEFAULT_WIDTH = 20;

    // configuration port index width and register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

    // handshake between the sequencer and the multiply unit
    typedef struct packed {
        logic start;
    } t_mm_cmd;

    typedef struct packed {
        logic done;
    } t_mm_status;

endpackage

// ----- hw/rtl/modexp_mulmod.sv -----
// bit-serial modular multiplier, one multiplier bit per cycle
module modexp_mulmod #(
    parameter int WIDTH = modexp_pkg::DEFAULT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  modexp_pkg::t_mm_cmd    i_cmd,
    input  logic [WIDTH-1:0]       i_a,
    input  logic [WIDTH-1:0]       i_b,
    input  logic [WIDTH-1:0]       i_m,
    output modexp_pkg::t_mm_status o_status,
    output logic [WIDTH-1:0]       o_result
);

    localparam int TW = WIDTH + 2;
    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(WIDTH - 1);

    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_b;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [TW-1:0] w_t, w_m1, w_m2;

    // r = 2r + bit*a, then bring back below m (t < 3m)
    always_comb begin
        w_m1 = {2'b00, i_m};
        w_m2 = {1'b0, i_m, 1'b0};
        w_t  = {1'b0, r_acc, 1'b0} + (r_b[WIDTH-1] ? {2'b00, i_a} : TW'(0));
        if (w_t >= w_m2) begin
            n_acc = WIDTH'(w_t - w_m2);
        end else if (w_t >= w_m1) begin
            n_acc = WIDTH'(w_t - w_m1);
        end else begin
            n_acc = w_t[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
            r_b   <= i_b;
            r_cnt <= LAST_STEP;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b << 1;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_status.done = r_done;
    assign o_result      = r_acc;

endmodule

// ----- hw/rtl/modular_exponentiation_top.sv -----
// modular exponentiation top level: config registers and square-and-multiply sequencer
//
// Each accepted base word returns base^exponent mod modulus, computed by square-and-multiply
// from the top exponent bit down. All arithmetic runs through one bit-serial modular
// multiplier. A word needs one reduction of the base, one squaring per exponent bit and
// one extra multiply per set exponent bit. A modulus below two returns 0. The input is
// stalled from acceptance until the result word has been taken. Write modulus and exponent
// only while idle.
module modular_exponentiation_top #(
    parameter int WIDTH = modexp_pkg::DEFAULT_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [modexp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH-1:0]                 i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [WIDTH-1:0]                 i_base_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [WIDTH-1:0]                 o_power_result
);

    localparam int BW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [BW-1:0] TOP_BIT = BW'(WIDTH - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_MULT   = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_exponent;
    logic [2:0]       r_state;
    logic             r_mm_start;
    logic [BW-1:0]    r_bit;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_result;

    logic [WIDTH-1:0]       w_mm_a, w_mm_b, w_mm_result;
    modexp_pkg::t_mm_cmd    w_mm_cmd;
    modexp_pkg::t_mm_status w_mm_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= WIDTH'(2);
            r_exponent <= WIDTH'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                modexp_pkg::REG_MODULUS:  r_modulus  <= i_cfg_wdata;
                modexp_pkg::REG_EXPONENT: r_exponent <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // operand selection; a times b with b consumed msb first
    always_comb begin
        case (r_state)
            ST_REDUCE: begin
                w_mm_a = WIDTH'(1);
                w_mm_b = r_base;
            end
            ST_MULT: begin
                w_mm_a = r_base;
                w_mm_b = r_acc;
            end
            default: begin
                w_mm_a = r_acc;
                w_mm_b = r_acc;
            end
        endcase
    end

    assign w_mm_cmd.start = r_mm_start;

    modexp_mulmod #(
        .WIDTH(WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_mm_cmd),
        .i_a      (w_mm_a),
        .i_b      (w_mm_b),
        .i_m      (r_modulus),
        .o_status (w_mm_status),
        .o_result (w_mm_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mm_start <= 1'b0;
        end else begin
            r_mm_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (r_modulus < WIDTH'(2)) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state    <= ST_REDUCE;
                            r_mm_start <= 1'b1;
                        end
                    end
                end
                ST_REDUCE: begin
                    if (w_mm_status.done) begin
                        r_state    <= ST_SQUARE;
                        r_mm_start <= 1'b1;
                    end
                end
                ST_SQUARE: begin
                    if (w_mm_status.done) begin
                        if (r_exponent[r_bit]) begin
                            r_state    <= ST_MULT;
                            r_mm_start <= 1'b1;
                        end else if (r_bit == '0) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_mm_start <= 1'b1;
                        end
                    end
                end
                ST_MULT: begin
                    if (w_mm_status.done) begin
                        if (r_bit == '0) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state    <= ST_SQUARE;
                            r_mm_start <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_base   <= i_base_value;
                r_result <= '0;
            end
            ST_REDUCE: begin
                if (w_mm_status.done) begin
                    r_base <= w_mm_result;
                    r_acc  <= WIDTH'(1);
                    r_bit  <= TOP_BIT;
                end
            end
            ST_SQUARE: begin
                if (w_mm_status.done) begin
                    r_acc <= w_mm_result;
                    if (!r_exponent[r_bit]) begin
                        if (r_bit == '0) begin
                            r_result <= w_mm_result;
                        end else begin
                            r_bit <= r_bit - BW'(1);
                        end
                    end
                end
            end
            ST_MULT: begin
                if (w_mm_status.done) begin
                    r_acc <= w_mm_result;
                    if (r_bit == '0) begin
                        r_result <= w_mm_result;
                    end else begin
                        r_bit <= r_bit - BW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = (r_state == ST_OUT);
    assign o_power_result = r_result;

endmodule
